>>> rtl/core/scancode_line_editor_top_assert.svh
// Assertion macros for the scancode line editor checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef SCANCODE_LINE_EDITOR_TOP_ASSERT_SVH
`define SCANCODE_LINE_EDITOR_TOP_ASSERT_SVH

// Condition and consequence in the same cycle.
`define SLE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scancode_line_editor: check failed");

// Consequence in the cycle after the condition.
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scancode_line_editor: check failed");

`endif

>>> rtl/core/sle_pkg.sv
// Shared types, scancodes and key tables of the scancode line editor.
// No dependencies; used by the top level and its checker.
package sle_pkg;

   localparam int LINE_SIZE = 128;
   localparam int TERMINALS = 3;
   localparam int CNT_W     = 8;
   localparam int TERM_W    = 2;
   localparam int CHAR_W    = 7;
   localparam int POS_W     = 7;

   typedef enum logic [2:0] {
      KIND_STORE  = 3'd0,
      KIND_ERASE  = 3'd1,
      KIND_DONE   = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_SWITCH = 3'd4
   } kind_type;

   localparam logic [7:0] SC_CTRL_DN = 8'h1D;
   localparam logic [7:0] SC_CTRL_UP = 8'h9D;
   localparam logic [7:0] SC_LSH_DN  = 8'h2A;
   localparam logic [7:0] SC_LSH_UP  = 8'hAA;
   localparam logic [7:0] SC_RSH_DN  = 8'h36;
   localparam logic [7:0] SC_RSH_UP  = 8'hB6;
   localparam logic [7:0] SC_CAPS    = 8'h3A;
   localparam logic [7:0] SC_ALT_DN  = 8'h38;
   localparam logic [7:0] SC_ALT_UP  = 8'hB8;
   localparam logic [7:0] SC_RET     = 8'h1C;
   localparam logic [7:0] SC_BKSP    = 8'h0E;
   localparam logic [7:0] SC_KEY_L   = 8'h26;
   localparam logic [7:0] SC_KP_STAR = 8'h37;
   localparam logic [7:0] SC_FN1     = 8'h3B;
   localparam logic [7:0] SC_FN3     = 8'h3D;
   localparam logic [7:0] SC_TAB     = 8'h0F;
   localparam logic [7:0] SC_FIRST   = 8'h02;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

   // Key map. Letters return their lower-case code with the letter flag set and
   // are raised to upper case when exactly one of shift and caps applies. Every
   // other key returns its plain or shifted symbol.
   function automatic logic [CHAR_W-1:0] key_char(input logic [7:0] sc,
                                                  input logic shifted,
                                                  input logic caps);
      logic [CHAR_W-1:0] plain;
      logic [CHAR_W-1:0] shift;
      logic              letter;
      plain  = '0;
      shift  = '0;
      letter = 1'b0;
      unique case (sc)
         8'h02: begin plain = 7'h31; shift = 7'h21; end
         8'h03: begin plain = 7'h32; shift = 7'h40; end
         8'h04: begin plain = 7'h33; shift = 7'h23; end
         8'h05: begin plain = 7'h34; shift = 7'h24; end
         8'h06: begin plain = 7'h35; shift = 7'h25; end
         8'h07: begin plain = 7'h36; shift = 7'h5E; end
         8'h08: begin plain = 7'h37; shift = 7'h26; end
         8'h09: begin plain = 7'h38; shift = 7'h2A; end
         8'h0A: begin plain = 7'h39; shift = 7'h28; end
         8'h0B: begin plain = 7'h30; shift = 7'h29; end
         8'h0C: begin plain = 7'h2D; shift = 7'h5F; end
         8'h0D: begin plain = 7'h3D; shift = 7'h2B; end
         8'h0E: begin plain = 7'h08; shift = 7'h08; end
         8'h0F: begin plain = 7'h20; shift = 7'h20; end
         8'h10: begin plain = 7'h71; letter = 1'b1; end
         8'h11: begin plain = 7'h77; letter = 1'b1; end
         8'h12: begin plain = 7'h65; letter = 1'b1; end
         8'h13: begin plain = 7'h72; letter = 1'b1; end
         8'h14: begin plain = 7'h74; letter = 1'b1; end
         8'h15: begin plain = 7'h79; letter = 1'b1; end
         8'h16: begin plain = 7'h75; letter = 1'b1; end
         8'h17: begin plain = 7'h69; letter = 1'b1; end
         8'h18: begin plain = 7'h6F; letter = 1'b1; end
         8'h19: begin plain = 7'h70; letter = 1'b1; end
         8'h1A: begin plain = 7'h5B; shift = 7'h7B; end
         8'h1B: begin plain = 7'h5D; shift = 7'h7D; end
         8'h1C: begin plain = 7'h0A; shift = 7'h0A; end
         8'h1E: begin plain = 7'h61; letter = 1'b1; end
         8'h1F: begin plain = 7'h73; letter = 1'b1; end
         8'h20: begin plain = 7'h64; letter = 1'b1; end
         8'h21: begin plain = 7'h66; letter = 1'b1; end
         8'h22: begin plain = 7'h67; letter = 1'b1; end
         8'h23: begin plain = 7'h68; letter = 1'b1; end
         8'h24: begin plain = 7'h6A; letter = 1'b1; end
         8'h25: begin plain = 7'h6B; letter = 1'b1; end
         8'h26: begin plain = 7'h6C; letter = 1'b1; end
         8'h27: begin plain = 7'h3B; shift = 7'h3A; end
         8'h28: begin plain = 7'h27; shift = 7'h22; end
         8'h29: begin plain = 7'h60; shift = 7'h7E; end
         8'h2B: begin plain = 7'h5C; shift = 7'h7C; end
         8'h2C: begin plain = 7'h7A; letter = 1'b1; end
         8'h2D: begin plain = 7'h78; letter = 1'b1; end
         8'h2E: begin plain = 7'h63; letter = 1'b1; end
         8'h2F: begin plain = 7'h76; letter = 1'b1; end
         8'h30: begin plain = 7'h62; letter = 1'b1; end
         8'h31: begin plain = 7'h6E; letter = 1'b1; end
         8'h32: begin plain = 7'h6D; letter = 1'b1; end
         8'h33: begin plain = 7'h2C; shift = 7'h3C; end
         8'h34: begin plain = 7'h2E; shift = 7'h3E; end
         8'h35: begin plain = 7'h2F; shift = 7'h3F; end
         8'h39: begin plain = 7'h20; shift = 7'h20; end
         default: begin plain = '0; shift = '0; end
      endcase
      if (letter) begin
         key_char = (shifted ^ caps) ? (plain & 7'h5F) : plain;
      end else begin
         key_char = shifted ? shift : plain;
      end
   endfunction

endpackage

>>> rtl/core/scancode_line_editor_top.sv
// Scancode line editor: set-1 scancodes in, line edit items out.
// Depends on sle_pkg.
//
// Usage
// The req_ channel carries one raw set-1 scancode per item. The rsp_ channel
// carries the line edits that a scancode causes: a stored character, an
// erased character, a finished line, a cleared line or a terminal switch.
// rsp_last marks the final item of one scancode. Modifier codes, ignored codes,
// a full line and backspace on an empty line give no result item at all.
//
// Timing
// A scancode is decoded in the cycle it is accepted and its results sit in the
// result register from the next cycle on. The result register drains one item
// per cycle while the receiver does not stall; a scancode causes one result
// item for most keys and four for a tab that fits. A new scancode is taken in
// the same cycle as the final result of the previous one leaves, so
// single-result keys stream at one per cycle while the receiver is ready.
//
// Reset clears the modifier flags, caps lock, the shown terminal and every
// line count, and empties the result register. When the receiver stalls the
// result register holds its item and req_ready stays low until it drains.
module scancode_line_editor_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scancode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [6:0] rsp_char_code,
   output logic [6:0] rsp_position,
   output logic [1:0] rsp_terminal,
   output logic       rsp_last
);

   // Editor state.
   logic                          ctrl_ff, ctrl_in;
   logic                          lshift_ff, lshift_in;
   logic                          rshift_ff, rshift_in;
   logic                          alt_ff, alt_in;
   logic                          caps_ff, caps_in;
   logic [sle_pkg::TERM_W-1:0]    shown_ff, shown_in;
   logic [sle_pkg::CNT_W-1:0]     count_ff [sle_pkg::TERMINALS];

   // Result register: one scancode's burst of result items.
   logic                          busy_ff, busy_in;
   sle_pkg::kind_type             kind_ff, kind_in;
   logic [sle_pkg::CHAR_W-1:0]    char_ff, char_in;
   logic [sle_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [sle_pkg::TERM_W-1:0]    term_ff, term_in;
   logic [1:0]                    left_ff, left_in;

   logic                          take;
   logic                          drained;
   logic                          accept;
   logic [sle_pkg::TERM_W-1:0]    term;
   logic [sle_pkg::CNT_W-1:0]     cnt;
   logic [7:0]                    sc;
   logic [sle_pkg::TERM_W-1:0]    target;
   logic                          tab_fits;
   logic                          has_res;
   logic                          cnt_we;
   logic [sle_pkg::CNT_W-1:0]     cnt_wdata;

   // Handshake: the result register frees up as its final item leaves.
   assign take      = busy_ff && rsp_ready;
   assign drained   = take && (left_ff == 2'd0);
   assign req_ready = !busy_ff || drained;
   assign accept    = req_valid && req_ready;

   assign rsp_valid     = busy_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_char_code = char_ff;
   assign rsp_position  = pos_ff;
   assign rsp_terminal  = term_ff;
   assign rsp_last      = (left_ff == 2'd0);

   // The terminal being edited and its current line count. Only the low bits
   // of the offset from F1 matter, as the switch keys span three codes.
   assign sc        = req_scancode;
   assign term      = (shown_ff < sle_pkg::TERMINALS) ? shown_ff : '0;
   assign cnt       = count_ff[term];
   assign target    = sc[sle_pkg::TERM_W-1:0] - sle_pkg::SC_FN1[sle_pkg::TERM_W-1:0];
   assign tab_fits  = ({1'b0, cnt} + 9'd3) < 9'(sle_pkg::LINE_SIZE);

   // Decode of one scancode. The checks run in the order the editor defines:
   // modifiers first, then terminal switching, then the key range filter and
   // finally the editing keys.
   always_comb begin
      ctrl_in   = ctrl_ff;
      lshift_in = lshift_ff;
      rshift_in = rshift_ff;
      alt_in    = alt_ff;
      caps_in   = caps_ff;
      shown_in  = shown_ff;
      cnt_we    = 1'b0;
      cnt_wdata = cnt;
      has_res   = 1'b0;
      kind_in   = sle_pkg::KIND_STORE;
      char_in   = '0;
      pos_in    = '0;
      term_in   = term;
      left_in   = 2'd0;
      if (accept) begin
         priority if (sc == sle_pkg::SC_CTRL_DN) begin
            ctrl_in = 1'b1;
         end else if (sc == sle_pkg::SC_CTRL_UP) begin
            ctrl_in = 1'b0;
         end else if (sc == sle_pkg::SC_LSH_DN) begin
            lshift_in = 1'b1;
         end else if (sc == sle_pkg::SC_LSH_UP) begin
            lshift_in = 1'b0;
         end else if (sc == sle_pkg::SC_RSH_DN) begin
            rshift_in = 1'b1;
         end else if (sc == sle_pkg::SC_RSH_UP) begin
            rshift_in = 1'b0;
         end else if (sc == sle_pkg::SC_CAPS) begin
            caps_in = !caps_ff;
         end else if (sc == sle_pkg::SC_ALT_DN) begin
            alt_in = 1'b1;
         end else if (sc == sle_pkg::SC_ALT_UP) begin
            alt_in = 1'b0;
         end else if (alt_ff && sc >= sle_pkg::SC_FN1 && sc <= sle_pkg::SC_FN3) begin
            // A switch to a terminal that does not exist is dropped.
            if (target < sle_pkg::TERMINALS) begin
               shown_in = target;
               has_res  = 1'b1;
               kind_in  = sle_pkg::KIND_SWITCH;
               term_in  = target;
            end
         end else if (sc < sle_pkg::SC_FIRST || sc >= sle_pkg::SC_FN1 ||
                      sc == sle_pkg::SC_KP_STAR) begin
            // Outside the key range: nothing happens.
         end else if (sc == sle_pkg::SC_BKSP) begin
            if (cnt != '0) begin
               cnt_we    = 1'b1;
               cnt_wdata = cnt - 8'd1;
               has_res   = 1'b1;
               kind_in   = sle_pkg::KIND_ERASE;
               pos_in    = cnt_wdata[sle_pkg::POS_W-1:0];
            end
         end else if (sc == sle_pkg::SC_RET) begin
            has_res = 1'b1;
            kind_in = sle_pkg::KIND_DONE;
         end else if (ctrl_ff && sc == sle_pkg::SC_KEY_L) begin
            cnt_we    = 1'b1;
            cnt_wdata = '0;
            has_res   = 1'b1;
            kind_in   = sle_pkg::KIND_CLEAR;
         end else if (sc == sle_pkg::SC_TAB && tab_fits) begin
            // Four spaces; the result register steps the position itself.
            cnt_we    = 1'b1;
            cnt_wdata = cnt + 8'd4;
            has_res   = 1'b1;
            char_in   = sle_pkg::CHAR_SPACE;
            pos_in    = cnt[sle_pkg::POS_W-1:0];
            left_in   = 2'd3;
         end else if (cnt < sle_pkg::LINE_SIZE) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt + 8'd1;
            has_res   = 1'b1;
            char_in   = sle_pkg::key_char(sc, lshift_ff || rshift_ff, caps_ff);
            pos_in    = cnt[sle_pkg::POS_W-1:0];
         end else begin
            // Line full: the key is dropped.
         end
      end
   end

   assign busy_in = accept ? has_res : (busy_ff && !drained);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         left_ff   <= 2'd0;
         ctrl_ff   <= 1'b0;
         lshift_ff <= 1'b0;
         rshift_ff <= 1'b0;
         alt_ff    <= 1'b0;
         caps_ff   <= 1'b0;
         shown_ff  <= '0;
         for (int i = 0; i < sle_pkg::TERMINALS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         busy_ff   <= busy_in;
         ctrl_ff   <= ctrl_in;
         lshift_ff <= lshift_in;
         rshift_ff <= rshift_in;
         alt_ff    <= alt_in;
         caps_ff   <= caps_in;
         shown_ff  <= shown_in;
         if (cnt_we) begin
            count_ff[term] <= cnt_wdata;
         end
         if (accept) begin
            left_ff <= left_in;
         end else if (take && !drained) begin
            left_ff <= left_ff - 2'd1;
         end
      end
   end

   // Payload of the result register; a tab burst advances the position as
   // each space leaves.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         pos_ff  <= pos_in;
         term_ff <= term_in;
      end else if (take && !drained) begin
         pos_ff <= pos_ff + 7'd1;
      end
   end

endmodule

>>> rtl/core/sle_checker.sv
// Port-level checker of the scancode line editor, bound to the top level.
// Depends on sle_pkg and scancode_line_editor_top_assert.svh.
`include "scancode_line_editor_top_assert.svh"

module sle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [6:0] rsp_char_code,
   input logic [6:0] rsp_position,
   input logic [1:0] rsp_terminal,
   input logic       rsp_last
);

   logic        req_stall;
   logic        tail_store;
   logic        no_char;
   logic        no_pos;
   logic        store_valid;
   logic [19:0] rsp_word;
   logic [6:0]  pos_next_ff, pos_next_in;

   assign req_stall   = req_valid && !req_ready;
   assign tail_store  = rsp_valid && rsp_ready && !rsp_last;
   assign no_char     = rsp_valid && (rsp_kind != sle_pkg::KIND_STORE);
   assign no_pos      = no_char && (rsp_kind != sle_pkg::KIND_ERASE);
   assign store_valid = rsp_valid && (rsp_kind == sle_pkg::KIND_STORE);
   assign rsp_word    = {rsp_kind, rsp_char_code, rsp_position, rsp_terminal, rsp_last};
   assign pos_next_in = rsp_position + 7'd1;

   always_ff @(posedge clock) begin
      pos_next_ff <= pos_next_in;
   end

   // A stalled result item holds still.
   `SLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // Only stored characters carry a character code.
   `SLE_ASSERT_NOW(a_char_zero, no_char, rsp_char_code == 7'd0)

   // Line done, clear and switch items carry no position.
   `SLE_ASSERT_NOW(a_pos_zero, no_pos, rsp_position == 7'd0)

   // A burst of spaces continues at the next position on the same terminal.
   `SLE_ASSERT_NEXT(a_burst_step, tail_store, store_valid && rsp_position == pos_next_ff && $stable(rsp_terminal))

   // A scancode is only refused while a result item waits.
   `SLE_ASSERT_NOW(a_req_stall, req_stall, rsp_valid)

endmodule

bind scancode_line_editor_top sle_checker u_sle_checker (.*);
